FILE: rtl/assert_macros.svh
// Assertion helpers shared by the RTL files that carry checks.
// Each macro takes a label, the clock, the reset and the property text.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// When the antecedent holds, the consequent must hold in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

`endif

FILE: rtl/les_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED effect sequencer package
// Payload types, register indexes, mode codes and the gamma table.
// ----------------------------------------------------------------------------
package les_pkg;

   typedef struct packed {
      logic        req_type;
      logic [31:0] now_ms;
   } req_payload_type;

   typedef struct packed {
      logic       color_is_hsv;
      logic [8:0] hue;
      logic [7:0] saturation;
      logic [7:0] value;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] interval_ms;
      logic       finished;
   } rsp_payload_type;

   // Divider command and status between the sequencer and the shared unit.
   localparam int DivWidth = 41;

   typedef struct packed {
      logic                start;
      logic [DivWidth-1:0] dividend;
      logic [31:0]         divisor;
      logic [5:0]          iterations;
   } div_cmd_type;

   typedef struct packed {
      logic        done;
      logic [8:0]  quotient;
      logic [31:0] remainder;
   } div_sts_type;

   localparam logic [2:0] CsrEffectMode     = 3'd0;
   localparam logic [2:0] CsrRainbowCycleMs = 3'd1;
   localparam logic [2:0] CsrBreatheHue     = 3'd2;
   localparam logic [2:0] CsrFlashRed       = 3'd3;
   localparam logic [2:0] CsrFlashGreen     = 3'd4;
   localparam logic [2:0] CsrFlashBlue      = 3'd5;
   localparam logic [2:0] CsrFlashCount     = 3'd6;
   localparam logic [2:0] CsrFlashEndOn     = 3'd7;

   localparam logic [1:0] ModeIdle    = 2'd0;
   localparam logic [1:0] ModeRainbow = 2'd1;
   localparam logic [1:0] ModeBreathe = 2'd2;
   localparam logic [1:0] ModeFlash   = 2'd3;

   localparam logic ReqTick    = 1'b0;
   localparam logic ReqRestart = 1'b1;

   localparam logic [31:0] RainbowCycleReset = 32'd18000;
   localparam logic [7:0]  RainbowSatVal     = 8'd200;
   localparam logic [7:0]  FullScale         = 8'd255;
   localparam logic [7:0]  IntervalRainbow   = 8'd50;
   localparam logic [7:0]  IntervalBreathe   = 8'd25;
   localparam logic [7:0]  IntervalFlash     = 8'd250;
   localparam logic [7:0]  IntervalDone      = 8'd0;
   localparam logic [5:0]  ModIterations     = 6'd32;
   localparam logic [5:0]  HueIterations     = 6'd41;

   typedef logic [7:0] gamma_table_type [0:255];

   // round(x^3 / 65025), built at elaboration.
   function automatic gamma_table_type build_gamma_table();
      gamma_table_type tbl;
      longint unsigned cube;
      for (int x = 0; x < 256; x++) begin
         cube   = longint'(x) * longint'(x) * longint'(x);
         tbl[x] = 8'((2 * cube + 65025) / 130050);
      end
      return tbl;
   endfunction

   localparam gamma_table_type GammaTable = build_gamma_table();

endpackage

FILE: rtl/les_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED effect sequencer divider
// Restoring shift-subtract divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module les_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  les_pkg::div_cmd_type cmd,
   output les_pkg::div_sts_type sts
);

   logic [les_pkg::DivWidth-1:0] shift_ff, shift_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] divisor_ff, divisor_in;
   logic [8:0]  quo_ff, quo_in;
   logic [5:0]  count_ff, count_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;

   logic [32:0] trial;
   logic [32:0] diff;
   logic        fits;

   // The partial remainder stays below the divisor, so 33 bits cover the trial.
   assign trial = {rem_ff, shift_ff[les_pkg::DivWidth-1]};
   assign diff  = trial - {1'b0, divisor_ff};
   assign fits  = trial >= {1'b0, divisor_ff};

   always_comb begin
      shift_in   = shift_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      quo_in     = quo_ff;
      count_in   = count_ff;
      busy_in    = busy_ff;
      done_in    = 1'b0;
      if (cmd.start) begin
         shift_in   = cmd.dividend;
         rem_in     = '0;
         divisor_in = cmd.divisor;
         quo_in     = '0;
         count_in   = cmd.iterations;
         busy_in    = 1'b1;
      end else if (busy_ff) begin
         shift_in = {shift_ff[les_pkg::DivWidth-2:0], 1'b0};
         rem_in   = fits ? diff[31:0] : trial[31:0];
         quo_in   = {quo_ff[7:0], fits};
         count_in = count_ff - 6'd1;
         if (count_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      shift_in_unused_guard: begin
         shift_ff   <= shift_in;
         rem_ff     <= rem_in;
         divisor_ff <= divisor_in;
         quo_ff     <= quo_in;
      end
      if (reset) begin
         count_ff <= '0;
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         busy_ff  <= busy_in;
         done_ff  <= done_in;
      end
   end

   assign sts.done      = done_ff;
   assign sts.quotient  = quo_ff;
   assign sts.remainder = rem_ff;

endmodule

FILE: rtl/led_effect_sequencer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED effect sequencer core
// Rainbow, breathe and flash colour generator for a single LED.
// ----------------------------------------------------------------------------
// The block takes request transactions on the req_ channel (valid/ready) and
// returns at most one colour per request on the rsp_ channel. A restart
// request reloads the effect state from the registers and gives no response;
// a tick request advances the selected effect and gives one colour, except
// when no effect is running, in which case nothing is returned.
// Registers are written through the csr_ channel, which is always ready.
//
// One request is handled at a time and req_ready is low while it is worked
// on. Restart and idle ticks leave req_ready high. A breathe, flash or
// zero-sweep rainbow tick puts its colour in the result staging register,
// which then loads the output register. Any other rainbow tick runs 32
// divider steps for now_ms mod cycle, registers the remainder times 360,
// restarts the divider, runs 41 steps to divide by the cycle, takes the
// quotient into the result staging register and then loads the output
// register. While the receiver stalls, the block still accepts the next
// request and works it as far as the result staging register, where it
// waits until the output register frees up. Reset is synchronous and active
// high: it clears the effect state, restores the register defaults and
// drops rsp_valid.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module led_effect_sequencer_core (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  les_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output les_pkg::rsp_payload_type rsp_payload,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [2:0]               csr_index,
   input  logic [31:0]              csr_data
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV_MOD,
      ST_MUL,
      ST_DIV_HUE,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;

   // Configuration registers.
   logic [1:0]  effect_mode_ff, effect_mode_in;
   logic [31:0] rainbow_cycle_ff, rainbow_cycle_in;
   logic [8:0]  breathe_hue_ff, breathe_hue_in;
   logic [7:0]  flash_red_ff, flash_red_in;
   logic [7:0]  flash_green_ff, flash_green_in;
   logic [7:0]  flash_blue_ff, flash_blue_in;
   logic [6:0]  flash_count_ff, flash_count_in;
   logic        flash_end_on_ff, flash_end_on_in;

   // Effect state.
   logic        effect_active_ff, effect_active_in;
   logic [8:0]  breathe_phase_ff, breathe_phase_in;
   logic [7:0]  toggles_ff, toggles_in;
   logic        flash_lit_ff, flash_lit_in;

   // Datapath and output.
   logic [les_pkg::DivWidth-1:0] product_ff, product_in;
   les_pkg::rsp_payload_type     result_ff, result_in;
   les_pkg::rsp_payload_type     rsp_payload_ff, rsp_payload_in;
   logic                         rsp_valid_ff, rsp_valid_in;

   les_pkg::div_cmd_type div_cmd;
   les_pkg::div_sts_type div_sts;

   logic                         req_accept;
   logic [7:0]                   breathe_level;
   logic [les_pkg::DivWidth-1:0] rem_wide;

   les_divider u_divider (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .sts   (div_sts)
   );

   assign req_ready  = (state_ff == ST_IDLE);
   assign req_accept = req_valid && req_ready;
   assign csr_ready  = 1'b1;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // The second half of the triangle mirrors the first: 511 - p is ~p[7:0].
   assign breathe_level = breathe_phase_ff[8] ? ~breathe_phase_ff[7:0]
                                              : breathe_phase_ff[7:0];
   assign rem_wide = {{(les_pkg::DivWidth-32){1'b0}}, div_sts.remainder};

   always_comb begin
      state_in         = state_ff;
      effect_mode_in   = effect_mode_ff;
      rainbow_cycle_in = rainbow_cycle_ff;
      breathe_hue_in   = breathe_hue_ff;
      flash_red_in     = flash_red_ff;
      flash_green_in   = flash_green_ff;
      flash_blue_in    = flash_blue_ff;
      flash_count_in   = flash_count_ff;
      flash_end_on_in  = flash_end_on_ff;
      effect_active_in = effect_active_ff;
      breathe_phase_in = breathe_phase_ff;
      toggles_in       = toggles_ff;
      flash_lit_in     = flash_lit_ff;
      product_in       = product_ff;
      result_in        = result_ff;
      rsp_payload_in   = rsp_payload_ff;
      rsp_valid_in     = rsp_valid_ff;
      div_cmd          = '0;
      div_cmd.divisor  = rainbow_cycle_ff;

      if (csr_valid && csr_ready) begin
         case (csr_index)
            les_pkg::CsrEffectMode:     effect_mode_in   = csr_data[1:0];
            les_pkg::CsrRainbowCycleMs: rainbow_cycle_in = csr_data;
            les_pkg::CsrBreatheHue:     breathe_hue_in   = csr_data[8:0];
            les_pkg::CsrFlashRed:       flash_red_in     = csr_data[7:0];
            les_pkg::CsrFlashGreen:     flash_green_in   = csr_data[7:0];
            les_pkg::CsrFlashBlue:      flash_blue_in    = csr_data[7:0];
            les_pkg::CsrFlashCount:     flash_count_in   = csr_data[6:0];
            les_pkg::CsrFlashEndOn:     flash_end_on_in  = csr_data[0];
            default:                    effect_mode_in   = effect_mode_ff;
         endcase
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_payload.req_type == les_pkg::ReqRestart) begin
                  breathe_phase_in = '0;
                  toggles_in       = {flash_count_ff, 1'b0};
                  flash_lit_in     = !flash_end_on_ff;
                  effect_active_in = (effect_mode_ff != les_pkg::ModeIdle);
               end else if (effect_active_ff && (effect_mode_ff != les_pkg::ModeIdle)) begin
                  result_in = '0;
                  case (effect_mode_ff)
                     les_pkg::ModeRainbow: begin
                        result_in.color_is_hsv = 1'b1;
                        result_in.saturation   = les_pkg::RainbowSatVal;
                        result_in.value        = les_pkg::RainbowSatVal;
                        result_in.interval_ms  = les_pkg::IntervalRainbow;
                        if (rainbow_cycle_ff == 32'd0) begin
                           state_in = ST_FINISH;
                        end else begin
                           div_cmd.start      = 1'b1;
                           div_cmd.dividend   = {req_payload.now_ms,
                                                 {(les_pkg::DivWidth-32){1'b0}}};
                           div_cmd.iterations = les_pkg::ModIterations;
                           state_in           = ST_DIV_MOD;
                        end
                     end
                     les_pkg::ModeBreathe: begin
                        result_in.color_is_hsv = 1'b1;
                        result_in.hue          = breathe_hue_ff;
                        result_in.saturation   = les_pkg::FullScale;
                        result_in.value        = les_pkg::GammaTable[breathe_level];
                        result_in.interval_ms  = les_pkg::IntervalBreathe;
                        breathe_phase_in       = breathe_phase_ff + 9'd1;
                        state_in               = ST_FINISH;
                     end
                     default: begin
                        if (toggles_ff == 8'd0) begin
                           result_in.red         = flash_red_ff;
                           result_in.green       = flash_green_ff;
                           result_in.blue        = flash_blue_ff;
                           result_in.interval_ms = les_pkg::IntervalDone;
                           result_in.finished    = 1'b1;
                           effect_active_in      = 1'b0;
                        end else begin
                           flash_lit_in = !flash_lit_ff;
                           if (!flash_lit_ff) begin
                              result_in.red   = flash_red_ff;
                              result_in.green = flash_green_ff;
                              result_in.blue  = flash_blue_ff;
                           end
                           result_in.interval_ms = les_pkg::IntervalFlash;
                           toggles_in            = toggles_ff - 8'd1;
                        end
                        state_in = ST_FINISH;
                     end
                  endcase
               end
            end
         end
         ST_DIV_MOD: begin
            if (div_sts.done) begin
               // Remainder times 360 as shifts and adds: 256 + 64 + 32 + 8.
               product_in = (rem_wide << 8) + (rem_wide << 6)
                          + (rem_wide << 5) + (rem_wide << 3);
               state_in   = ST_MUL;
            end
         end
         ST_MUL: begin
            div_cmd.start      = 1'b1;
            div_cmd.dividend   = product_ff;
            div_cmd.iterations = les_pkg::HueIterations;
            state_in           = ST_DIV_HUE;
         end
         ST_DIV_HUE: begin
            if (div_sts.done) begin
               result_in.hue = div_sts.quotient;
               state_in      = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_payload_in = result_ff;
               rsp_valid_in   = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      product_ff     <= product_in;
      result_ff      <= result_in;
      rsp_payload_ff <= rsp_payload_in;
      if (reset) begin
         state_ff         <= ST_IDLE;
         effect_mode_ff   <= les_pkg::ModeIdle;
         rainbow_cycle_ff <= les_pkg::RainbowCycleReset;
         breathe_hue_ff   <= '0;
         flash_red_ff     <= '0;
         flash_green_ff   <= '0;
         flash_blue_ff    <= '0;
         flash_count_ff   <= '0;
         flash_end_on_ff  <= 1'b1;
         effect_active_ff <= 1'b0;
         breathe_phase_ff <= '0;
         toggles_ff       <= '0;
         flash_lit_ff     <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         effect_mode_ff   <= effect_mode_in;
         rainbow_cycle_ff <= rainbow_cycle_in;
         breathe_hue_ff   <= breathe_hue_in;
         flash_red_ff     <= flash_red_in;
         flash_green_ff   <= flash_green_in;
         flash_blue_ff    <= flash_blue_in;
         flash_count_ff   <= flash_count_in;
         flash_end_on_ff  <= flash_end_on_in;
         effect_active_ff <= effect_active_in;
         breathe_phase_ff <= breathe_phase_in;
         toggles_ff       <= toggles_in;
         flash_lit_ff     <= flash_lit_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   // The divider only reports completion while the sequencer waits on it.
   `ASSERT_IMPLIES(a_div_done_in_div_state, clock, reset, div_sts.done,
      (state_ff == ST_DIV_MOD) || (state_ff == ST_DIV_HUE))

   // A rainbow hue always lands below a full turn.
   `ASSERT_IMPLIES(a_rainbow_hue_range, clock, reset,
      rsp_valid && (rsp_payload.interval_ms == les_pkg::IntervalRainbow),
      rsp_payload.hue < 9'd360)

   // The finishing result is an RGB colour with no further delay.
   `ASSERT_IMPLIES(a_finish_is_rgb, clock, reset, rsp_valid && rsp_payload.finished,
      !rsp_payload.color_is_hsv && (rsp_payload.interval_ms == les_pkg::IntervalDone))

endmodule

FILE: tb/tb_led_effect_sequencer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED effect sequencer core testbench
// Drives restart and tick transactions and predicts every colour response.
// ----------------------------------------------------------------------------
// A colour predictor mirrors the register file and the effect state. It is
// updated at each accepted register write and at each accepted request. The
// predicted colours wait in a queue that the response monitor checks in
// order, field by field. Named test tasks cover the register defaults, the
// rainbow extremes, the breathe hue range, the end of a flash, mode changes
// without a restart, output back-pressure, a breathe phase wrap, a long
// flash and finally random effect sequences.
// ----------------------------------------------------------------------------

module tb_led_effect_sequencer_core;

   localparam int DrainCycles = 100;        // well above the rainbow latency
   localparam int CycleLimit  = 1_000_000;
   localparam int IdleMax     = 18;

   typedef struct {
      logic [1:0]  mode;
      logic [31:0] sweep_len;
      logic [8:0]  hue;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [6:0]  count;
      logic        end_on;
   } effect_settings_type;

   logic                     clock       = 1'b0;
   logic                     reset       = 1'b1;
   logic                     req_valid   = 1'b0;
   logic                     req_ready;
   les_pkg::req_payload_type req_payload = '0;
   logic                     rsp_valid;
   logic                     rsp_ready   = 1'b0;
   les_pkg::rsp_payload_type rsp_payload;
   logic                     csr_valid   = 1'b0;
   logic                     csr_ready;
   logic [2:0]               csr_index   = '0;
   logic [31:0]              csr_data    = '0;

   // Predictor copy of the registers and of the effect state.
   effect_settings_type regs;
   logic                fx_active;
   logic [8:0]          phase_model;
   logic [7:0]          flips_pending;
   logic                lit;

   les_pkg::rsp_payload_type expected_colors[$];
   int unsigned              colors_predicted = 0;
   int unsigned              error_count      = 0;
   int unsigned              cycle_count      = 0;

   // Idling controls: the sender and the receiver each draw a wait per
   // transaction from 0 up to their maximum. A hold-off stalls the receiver.
   int unsigned source_gap_max = IdleMax;
   int unsigned sink_stall_max = IdleMax;
   int unsigned sink_hold_off  = 0;
   int unsigned sink_wait      = 0;

   led_effect_sequencer_core u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   always #10 clock = ~clock;

   // The run is cut off if it hangs; a hang counts as a failure.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CycleLimit) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Colour predictor
   // ---------------------------------------------------------------------

   task automatic predict_color(input les_pkg::req_payload_type rq, output bit produced,
                                output les_pkg::rsp_payload_type color);
      logic [31:0]     rem;
      logic [63:0]     scaled;
      logic [7:0]      ramp;
      longint unsigned cube;
      produced = 1'b0;
      color    = '0;
      // A restart reloads the effect state from the registers.
      if (rq.req_type == les_pkg::ReqRestart) begin
         phase_model   = '0;
         flips_pending = {regs.count, 1'b0};
         lit           = ~regs.end_on;
         fx_active     = (regs.mode != les_pkg::ModeIdle);
         return;
      end
      if (!fx_active || regs.mode == les_pkg::ModeIdle) return;
      produced = 1'b1;
      case (regs.mode)
         les_pkg::ModeRainbow: begin
            color.color_is_hsv = 1'b1;
            // A zero sweep length leaves the hue at zero.
            if (regs.sweep_len != 0) begin
               rem       = rq.now_ms % regs.sweep_len;
               scaled    = (64'(rem) * 64'd360) / 64'(regs.sweep_len);
               color.hue = scaled[8:0];
            end
            color.saturation  = les_pkg::RainbowSatVal;
            color.value       = les_pkg::RainbowSatVal;
            color.interval_ms = les_pkg::IntervalRainbow;
         end
         les_pkg::ModeBreathe: begin
            // Triangle 0..255..0 over 512 steps, then a cube gamma curve.
            ramp = (phase_model < 9'd256) ? phase_model[7:0]
                                          : 8'(9'd511 - phase_model);
            cube = longint'(ramp) * longint'(ramp) * longint'(ramp);
            color.color_is_hsv = 1'b1;
            color.hue          = regs.hue;
            color.saturation   = les_pkg::FullScale;
            color.value        = 8'((2 * cube + 65025) / 130050);
            color.interval_ms  = les_pkg::IntervalBreathe;
            phase_model        = phase_model + 9'd1;
         end
         default: begin
            if (flips_pending == 8'd0) begin
               color.red         = regs.red;
               color.green       = regs.green;
               color.blue        = regs.blue;
               color.interval_ms = les_pkg::IntervalDone;
               color.finished    = 1'b1;
               fx_active         = 1'b0;
            end else begin
               lit = ~lit;
               if (lit) begin
                  color.red   = regs.red;
                  color.green = regs.green;
                  color.blue  = regs.blue;
               end
               color.interval_ms = les_pkg::IntervalFlash;
               flips_pending     = flips_pending - 8'd1;
            end
         end
      endcase
   endtask

   // ---------------------------------------------------------------------
   // Request and register channels
   // ---------------------------------------------------------------------

   // Valid is left high after acceptance so that a back-to-back transaction
   // never lowers and raises it in the same time step. Any caller that stops
   // sending lowers it, in the step of the last acceptance.
   task automatic send_request(input logic kind, input logic [31:0] stamp);
      int unsigned              gap;
      bit                       produced;
      les_pkg::rsp_payload_type color;
      gap = $urandom_range(0, source_gap_max);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_payload <= '{req_type: kind, now_ms: stamp};
      req_valid   <= 1'b1;
      do @(posedge clock); while (!req_ready);
      predict_color('{req_type: kind, now_ms: stamp}, produced, color);
      if (produced) begin
         expected_colors.push_back(color);
         colors_predicted++;
      end
   endtask

   task automatic send_tick(input logic [31:0] stamp);
      send_request(les_pkg::ReqTick, stamp);
   endtask

   task automatic write_register(input logic [2:0] index, input logic [31:0] data,
                                 input bit last);
      csr_index <= index;
      csr_data  <= data;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      case (index)
         les_pkg::CsrEffectMode:     regs.mode      = data[1:0];
         les_pkg::CsrRainbowCycleMs: regs.sweep_len = data;
         les_pkg::CsrBreatheHue:     regs.hue       = data[8:0];
         les_pkg::CsrFlashRed:       regs.red       = data[7:0];
         les_pkg::CsrFlashGreen:     regs.green     = data[7:0];
         les_pkg::CsrFlashBlue:      regs.blue      = data[7:0];
         les_pkg::CsrFlashCount:     regs.count     = data[6:0];
         default:                    regs.end_on    = data[0];
      endcase
      if (last) csr_valid <= 1'b0;
   endtask

   // Stop offering requests and wait until every predicted colour is out.
   // At least one clock passes, so a following request may raise valid again.
   task automatic wait_for_colors();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_colors.size() != 0);
   endtask

   // Idle ticks and restarts give no response, so the block may still be busy
   // after the last colour. Let it settle before touching the registers.
   task automatic settle_block();
      wait_for_colors();
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic apply_settings(input effect_settings_type s);
      settle_block();
      write_register(les_pkg::CsrEffectMode,     32'(s.mode),     1'b0);
      write_register(les_pkg::CsrRainbowCycleMs, s.sweep_len,     1'b0);
      write_register(les_pkg::CsrBreatheHue,     32'(s.hue),      1'b0);
      write_register(les_pkg::CsrFlashRed,       32'(s.red),      1'b0);
      write_register(les_pkg::CsrFlashGreen,     32'(s.green),    1'b0);
      write_register(les_pkg::CsrFlashBlue,      32'(s.blue),     1'b0);
      write_register(les_pkg::CsrFlashCount,     32'(s.count),    1'b0);
      write_register(les_pkg::CsrFlashEndOn,     32'(s.end_on),   1'b1);
   endtask

   function automatic effect_settings_type random_settings(input logic [1:0] mode);
      effect_settings_type s;
      s.mode = mode;
      case ($urandom_range(0, 6))
         0:       s.sweep_len = 32'd0;
         1:       s.sweep_len = 32'd1;
         2:       s.sweep_len = 32'd360;
         3:       s.sweep_len = les_pkg::RainbowCycleReset;
         4:       s.sweep_len = 32'hFFFF_FFFF;
         5:       s.sweep_len = $urandom_range(2, 100000);
         default: s.sweep_len = $urandom;
      endcase
      s.hue    = ($urandom_range(0, 4) == 0) ? 9'($urandom_range(360, 511))
                                             : 9'($urandom_range(0, 359));
      s.red    = 8'($urandom);
      s.green  = 8'($urandom);
      s.blue   = 8'($urandom);
      s.count  = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(7, 127))
                                             : 7'($urandom_range(0, 6));
      s.end_on = 1'($urandom);
      return s;
   endfunction

   // Either side may run flat out or idle at random for a stretch.
   task automatic pick_idling();
      source_gap_max = ($urandom_range(0, 2) == 0) ? 0 : IdleMax;
      sink_stall_max = ($urandom_range(0, 2) == 0) ? 0 : IdleMax;
   endtask

   // ---------------------------------------------------------------------
   // Response monitor
   // ---------------------------------------------------------------------

   task automatic compare_field(input string name, input int unsigned want,
                                input int unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      les_pkg::rsp_payload_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_colors.size() == 0) begin
               $error("response transaction with no prediction waiting");
               error_count++;
            end else begin
               want = expected_colors.pop_front();
               compare_field("color_is_hsv", 32'(want.color_is_hsv),
                             32'(rsp_payload.color_is_hsv));
               compare_field("hue",          32'(want.hue),  32'(rsp_payload.hue));
               compare_field("saturation",   32'(want.saturation),
                             32'(rsp_payload.saturation));
               compare_field("value",        32'(want.value), 32'(rsp_payload.value));
               compare_field("red",          32'(want.red),   32'(rsp_payload.red));
               compare_field("green",        32'(want.green), 32'(rsp_payload.green));
               compare_field("blue",         32'(want.blue),  32'(rsp_payload.blue));
               compare_field("interval_ms",  32'(want.interval_ms),
                             32'(rsp_payload.interval_ms));
               compare_field("finished",     32'(want.finished),
                             32'(rsp_payload.finished));
            end
            sink_wait = $urandom_range(0, sink_stall_max);
         end
         // A requested hold-off is counted down here, one cycle per clock.
         if (sink_hold_off > 0) begin
            sink_hold_off--;
            rsp_ready <= 1'b0;
         end else if (sink_wait > 0) begin
            sink_wait--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Idle mode after reset, then rainbow on the default sweep length and a
   // flash on the default count of zero, which finishes on its first tick.
   task automatic test_register_defaults();
      send_request(les_pkg::ReqRestart, $urandom);
      send_tick($urandom);
      settle_block();
      write_register(les_pkg::CsrEffectMode, 32'(les_pkg::ModeRainbow), 1'b1);
      send_request(les_pkg::ReqRestart, 32'd0);
      send_tick(32'd17999);
      send_tick(32'd18000);
      send_tick(32'hFFFF_FFFF);
      settle_block();
      write_register(les_pkg::CsrEffectMode, 32'(les_pkg::ModeFlash), 1'b1);
      send_request(les_pkg::ReqRestart, $urandom);
      send_tick($urandom);
   endtask

   // Sweep lengths of one, of the full 32-bit range and of zero. The
   // rainbow stays active, so only the register changes between ticks.
   task automatic test_rainbow_extremes();
      effect_settings_type s;
      s           = random_settings(les_pkg::ModeRainbow);
      s.sweep_len = 32'd1;
      apply_settings(s);
      send_request(les_pkg::ReqRestart, $urandom);
      send_tick($urandom);
      settle_block();
      write_register(les_pkg::CsrRainbowCycleMs, 32'hFFFF_FFFF, 1'b1);
      send_tick(32'hFFFF_FFFE);
      settle_block();
      write_register(les_pkg::CsrRainbowCycleMs, 32'd0, 1'b1);
      send_tick(32'hFFFF_FFFF);
   endtask

   // Largest legal hue, then a hue above 359 written mid-effect, which the
   // block passes through on the next tick.
   task automatic test_breathe_hue_range();
      effect_settings_type s;
      s     = random_settings(les_pkg::ModeBreathe);
      s.hue = 9'd359;
      apply_settings(s);
      send_request(les_pkg::ReqRestart, $urandom);
      send_tick($urandom);
      settle_block();
      write_register(les_pkg::CsrBreatheHue, 32'd511, 1'b1);
      send_tick($urandom);
   endtask

   // One flash with each end polarity, full-scale colour, then a tick after
   // the finishing colour that must give nothing.
   task automatic test_flash_ends();
      effect_settings_type s;
      s        = random_settings(les_pkg::ModeFlash);
      s.red    = 8'hFF;
      s.green  = 8'hFF;
      s.blue   = 8'hFF;
      s.count  = 7'd1;
      s.end_on = 1'b0;
      apply_settings(s);
      send_request(les_pkg::ReqRestart, $urandom);
      repeat (3) send_tick($urandom);
      settle_block();
      write_register(les_pkg::CsrFlashEndOn, 32'd1, 1'b1);
      send_request(les_pkg::ReqRestart, $urandom);
      repeat (4) send_tick($urandom);
   endtask

   // A running flash is switched to breathe, to idle and back without a
   // restart; each tick runs whatever mode the register holds at that time.
   task automatic test_mode_switch();
      effect_settings_type s;
      s       = random_settings(les_pkg::ModeFlash);
      s.count = 7'd3;
      apply_settings(s);
      send_request(les_pkg::ReqRestart, $urandom);
      send_tick($urandom);
      settle_block();
      write_register(les_pkg::CsrEffectMode, 32'(les_pkg::ModeBreathe), 1'b1);
      send_tick($urandom);
      settle_block();
      write_register(les_pkg::CsrEffectMode, 32'(les_pkg::ModeIdle), 1'b1);
      send_tick($urandom);
      settle_block();
      write_register(les_pkg::CsrEffectMode, 32'(les_pkg::ModeFlash), 1'b1);
      send_tick($urandom);
   endtask

   // The receiver stalls long enough for the block to fill and hold off its
   // input while the sender keeps offering ticks. Afterwards the sender
   // pauses until everything has drained, then carries on.
   task automatic test_output_backpressure();
      apply_settings(random_settings(les_pkg::ModeBreathe));
      send_request(les_pkg::ReqRestart, $urandom);
      source_gap_max = 0;
      sink_hold_off  = 400;
      repeat (12) send_tick($urandom);
      wait_for_colors();
      source_gap_max = IdleMax;
      sink_stall_max = IdleMax;
      repeat (8) send_tick($urandom);
   endtask

   // More than a full 512-step triangle, so the phase wraps.
   task automatic test_breathe_phase_wrap();
      apply_settings(random_settings(les_pkg::ModeBreathe));
      send_request(les_pkg::ReqRestart, $urandom);
      for (int i = 0; i < 520; i++) begin
         if (i % 64 == 0) pick_idling();
         send_tick($urandom);
      end
   endtask

   // Largest flash count: 254 toggles plus the finishing colour.
   task automatic test_long_flash();
      effect_settings_type s;
      s       = random_settings(les_pkg::ModeFlash);
      s.count = 7'd127;
      apply_settings(s);
      send_request(les_pkg::ReqRestart, $urandom);
      for (int i = 0; i < 256; i++) begin
         if (i % 64 == 0) pick_idling();
         send_tick($urandom);
      end
   endtask

   // Random settings, mostly a restart followed by enough ticks to run the
   // effect; now and then a sequence without restart, a stray restart in
   // the middle, or a pause until all colours are out.
   task automatic test_random_sequences();
      effect_settings_type s;
      int unsigned         target;
      int unsigned         ticks;
      logic [1:0]          mode;
      logic [31:0]         stamp;
      target = colors_predicted + 260;
      while (colors_predicted < target) begin
         mode = ($urandom_range(0, 9) == 0) ? les_pkg::ModeIdle
                                            : 2'($urandom_range(1, 3));
         s    = random_settings(mode);
         apply_settings(s);
         pick_idling();
         if ($urandom_range(0, 9) != 0) send_request(les_pkg::ReqRestart, $urandom);
         ticks = (mode == les_pkg::ModeFlash) ? 2 * s.count + $urandom_range(1, 3)
                                              : $urandom_range(1, 30);
         for (int i = 0; i < ticks; i++) begin
            case ($urandom_range(0, 4))
               0:       stamp = s.sweep_len - 32'd1;
               1:       stamp = s.sweep_len;
               2:       stamp = ($urandom_range(0, 1) == 0) ? 32'd0 : 32'hFFFF_FFFF;
               default: stamp = $urandom;
            endcase
            if ($urandom_range(0, 19) == 0) send_request(les_pkg::ReqRestart, stamp);
            else send_tick(stamp);
            if ($urandom_range(0, 39) == 0) wait_for_colors();
         end
      end
   endtask

   initial begin
      regs = '{mode: les_pkg::ModeIdle, sweep_len: les_pkg::RainbowCycleReset,
               hue: '0, red: '0, green: '0, blue: '0, count: '0, end_on: 1'b1};
      fx_active     = 1'b0;
      phase_model   = '0;
      flips_pending = '0;
      lit           = 1'b0;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_register_defaults();
      test_rainbow_extremes();
      test_breathe_hue_range();
      test_flash_ends();
      test_mode_switch();
      test_output_backpressure();
      test_breathe_phase_wrap();
      test_long_flash();
      test_random_sequences();

      // Any late or extra response is still caught during the settling time.
      settle_block();
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
